// ===== rtl/smfd_pkg.sv =====
// Shared types and codes for the SMF track event decoder.
// Holds the item structs of both channels and the result kind codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smfd_pkg;

    localparam logic [3:0] KIND_NOTE_OFF    = 4'd0;
    localparam logic [3:0] KIND_NOTE_ON     = 4'd1;
    localparam logic [3:0] KIND_CONTROL     = 4'd2;
    localparam logic [3:0] KIND_PROGRAM     = 4'd3;
    localparam logic [3:0] KIND_PRESSURE    = 4'd4;
    localparam logic [3:0] KIND_PITCH       = 4'd5;
    localparam logic [3:0] KIND_META_HDR    = 4'd6;
    localparam logic [3:0] KIND_META_DATA   = 4'd7;
    localparam logic [3:0] KIND_UNSUPPORTED = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } smfd_in_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] delta_time;
        logic [3:0]  channel;
        logic [13:0] value1;
        logic [7:0]  value2;
        logic [7:0]  meta_type;
        logic [31:0] meta_length;
        logic [7:0]  payload_byte;
        logic        last;
    } smfd_out_t;

endpackage

`default_nettype wire

// ===== rtl/smfd_parser.sv =====
// Byte-level parse state and decode logic of the SMF track event decoder.
// Consumes the item held in the input register and forms at most one result.
// Depends on smfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smfd_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire smfd_pkg::smfd_in_t item,
    input  wire logic              take,
    output logic                   step,
    output logic                   res_valid,
    output smfd_pkg::smfd_out_t    res
);
    import smfd_pkg::*;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_VALUE1,
        PH_VALUE2,
        PH_PITCH_HI,
        PH_META_TYPE,
        PH_META_LEN,
        PH_META_DATA
    } phase_t;

    phase_t      phase_reg, phase_next, phase_c;
    logic [31:0] delta_reg, delta_next, delta_c;
    logic [7:0]  run_status_reg, run_status_next, run_status_c;
    logic [7:0]  cur_status_reg, cur_status_next, cur_status_c;
    logic [7:0]  first_reg, first_next, first_c;
    logic [7:0]  meta_type_reg, meta_type_next, meta_type_c;
    logic [31:0] len_reg, len_next, len_c;
    logic [31:0] remain_reg, remain_next, remain_c;
    logic        halted_reg, halted_next, halted_c;

    logic [7:0]  b;
    logic [31:0] len_new;
    logic [31:0] rem_dec;
    logic        first_step;
    logic        unsup;
    logic        done;

    function automatic logic status_ok(input logic [7:0] s);
        return (s[7:4] == 4'h8) || (s[7:4] == 4'h9) || (s[7:4] == 4'hB) ||
               (s[7:4] == 4'hC) || (s[7:4] == 4'hD) || (s[7:4] == 4'hE);
    endfunction

    assign b = item.data_byte;

    // Restart clears everything before the byte is decoded.
    assign phase_c      = item.restart ? PH_DELTA : phase_reg;
    assign delta_c      = item.restart ? 32'd0 : delta_reg;
    assign run_status_c = item.restart ? 8'd0 : run_status_reg;
    assign cur_status_c = item.restart ? 8'd0 : cur_status_reg;
    assign first_c      = item.restart ? 8'd0 : first_reg;
    assign meta_type_c  = item.restart ? 8'd0 : meta_type_reg;
    assign len_c        = item.restart ? 32'd0 : len_reg;
    assign remain_c     = item.restart ? 32'd0 : remain_reg;
    assign halted_c     = item.restart ? 1'b0 : halted_reg;

    assign len_new = {len_c[24:0], b[6:0]};
    assign rem_dec = remain_c - 32'd1;

    always_comb
    begin
        phase_next      = phase_c;
        delta_next      = delta_c;
        run_status_next = run_status_c;
        cur_status_next = cur_status_c;
        first_next      = first_c;
        meta_type_next  = meta_type_c;
        len_next        = len_c;
        remain_next     = remain_c;
        halted_next     = halted_c;
        first_step      = 1'b0;
        unsup           = 1'b0;
        done            = 1'b0;
        res_valid       = 1'b0;
        res             = '0;
        res.delta_time  = delta_c;

        if (!halted_c)
        begin
            unique case (phase_c)
                PH_DELTA:
                begin
                    delta_next = {delta_c[24:0], b[6:0]};
                    if (!b[7])
                    begin
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (b[7:4] == 4'hF)
                    begin
                        if (b != 8'hFF)
                        begin
                            unsup = 1'b1;
                        end
                        else
                        begin
                            cur_status_next = 8'hFF;
                            run_status_next = 8'hFF;
                            phase_next      = PH_META_TYPE;
                        end
                    end
                    else if (!b[7])
                    begin
                        cur_status_next = run_status_c;
                        if (!status_ok(run_status_c))
                        begin
                            unsup = 1'b1;
                        end
                        else
                        begin
                            first_next = b;
                            first_step = 1'b1;
                        end
                    end
                    else if (!status_ok(b))
                    begin
                        unsup = 1'b1;
                    end
                    else
                    begin
                        cur_status_next = b;
                        run_status_next = b;
                        phase_next      = PH_VALUE1;
                    end
                end
                PH_VALUE1:
                begin
                    first_next = b;
                    first_step = 1'b1;
                end
                PH_VALUE2:
                begin
                    res_valid   = 1'b1;
                    res.kind    = (cur_status_c[7:4] == 4'h8) ? KIND_NOTE_OFF :
                                  (cur_status_c[7:4] == 4'h9) ? KIND_NOTE_ON : KIND_CONTROL;
                    res.channel = cur_status_c[3:0];
                    res.value1  = {6'd0, first_c};
                    res.value2  = b;
                    res.last    = 1'b1;
                    done        = 1'b1;
                end
                PH_PITCH_HI:
                begin
                    res_valid   = 1'b1;
                    res.kind    = KIND_PITCH;
                    res.channel = cur_status_c[3:0];
                    res.value1  = {b[6:0], first_c[6:0]};
                    res.last    = 1'b1;
                    done        = 1'b1;
                end
                PH_META_TYPE:
                begin
                    meta_type_next = b;
                    len_next       = 32'd0;
                    phase_next     = PH_META_LEN;
                end
                PH_META_LEN:
                begin
                    len_next = len_new;
                    if (!b[7])
                    begin
                        remain_next     = len_new;
                        res_valid       = 1'b1;
                        res.kind        = KIND_META_HDR;
                        res.meta_type   = meta_type_c;
                        res.meta_length = len_new;
                        res.last        = (len_new == 32'd0);
                        if (len_new == 32'd0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_META_DATA;
                        end
                    end
                end
                PH_META_DATA:
                begin
                    remain_next      = rem_dec;
                    res_valid        = 1'b1;
                    res.kind         = KIND_META_DATA;
                    res.meta_type    = meta_type_c;
                    res.meta_length  = len_c;
                    res.payload_byte = b;
                    res.last         = (rem_dec == 32'd0);
                    done             = (rem_dec == 32'd0);
                end
            endcase
        end

        // Dispatch once the first data byte is known.
        if (first_step)
        begin
            unique case (cur_status_next[7:4])
                4'h8, 4'h9, 4'hB:
                begin
                    phase_next = PH_VALUE2;
                end
                4'hE:
                begin
                    phase_next = PH_PITCH_HI;
                end
                4'hC, 4'hD:
                begin
                    res_valid   = 1'b1;
                    res.kind    = (cur_status_next[7:4] == 4'hC) ? KIND_PROGRAM : KIND_PRESSURE;
                    res.channel = cur_status_next[3:0];
                    res.value1  = {6'd0, first_next};
                    res.last    = 1'b1;
                    done        = 1'b1;
                end
                default:
                begin
                    unsup = 1'b1;
                end
            endcase
        end

        if (unsup)
        begin
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = KIND_UNSUPPORTED;
            res.delta_time = delta_c;
            res.last       = 1'b1;
            halted_next    = 1'b1;
            done           = 1'b1;
        end

        if (done)
        begin
            phase_next = PH_DELTA;
            delta_next = 32'd0;
        end
    end

    assign step = item_valid && (take || !res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DELTA;
            delta_reg      <= '0;
            run_status_reg <= '0;
            cur_status_reg <= '0;
            first_reg      <= '0;
            meta_type_reg  <= '0;
            len_reg        <= '0;
            remain_reg     <= '0;
            halted_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            delta_reg      <= delta_next;
            run_status_reg <= run_status_next;
            cur_status_reg <= cur_status_next;
            first_reg      <= first_next;
            meta_type_reg  <= meta_type_next;
            len_reg        <= len_next;
            remain_reg     <= remain_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smfd_out_reg.sv =====
// Result register of the SMF track event decoder.
// Holds one decoded item until the receiver takes it; depends on smfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smfd_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire smfd_pkg::smfd_out_t res,
    input  wire logic               stall,
    output logic                    take,
    output logic                    valid,
    output smfd_pkg::smfd_out_t     item
);
    import smfd_pkg::*;

    logic      valid_reg;
    smfd_out_t item_reg;

    assign take  = !valid_reg || !stall;
    assign valid = valid_reg;
    assign item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && load)
        begin
            item_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smf_event_decoder.sv =====
// Top level of the SMF track event decoder: input register, parser, result register.
// Depends on smfd_pkg, smfd_parser and smfd_out_reg.
//
// Usage:
//   track_* carries one raw track byte per item, with a restart flag that clears
//   the parser, running status and halt before that byte is decoded.
//   evt_* carries decoded results: channel events, meta header and meta data
//   items, and an unsupported item after which the parser halts until restart.
//   Bytes that finish nothing (delta time, status, first data bytes) give no item.
//   Path: a byte is accepted into the input register; when the parser steps, its
//   result is loaded into the result register and then shows on evt_*.
//   Throughput: one byte per cycle while track_stall is low; each byte passes the
//   input register and one level of decode logic, and its result the result register.
//   Stall: while a result waits under evt_stall, bytes that give no result keep
//   passing through the input register; track_stall rises only when the byte
//   held in the input register would produce a result that has nowhere to go.
//   Reset: rst_n clears both registers' valid flags and all parse state.
`timescale 1ns / 1ps
`default_nettype none

module smf_event_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               track_valid,
    output logic                    track_stall,
    input  wire smfd_pkg::smfd_in_t  track_item,
    output logic                    evt_valid,
    input  wire logic               evt_stall,
    output smfd_pkg::smfd_out_t     evt_item
);
    import smfd_pkg::*;

    logic      in_valid_reg;
    smfd_in_t  in_item_reg;
    logic      step;
    logic      take;
    logic      res_valid;
    smfd_out_t res;

    assign track_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (track_valid && !track_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (track_valid && !track_stall)
        begin
            in_item_reg <= track_item;
        end
    end

    smfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .take       (take),
        .step       (step),
        .res_valid  (res_valid),
        .res        (res)
    );

    smfd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step && res_valid),
        .res   (res),
        .stall (evt_stall),
        .take  (take),
        .valid (evt_valid),
        .item  (evt_item)
    );

endmodule

`default_nettype wire

// ===== rtl/smfd_checker.sv =====
// Port-level checks for the SMF track event decoder, bound to the top level.
// Depends on smfd_pkg and smf_event_decoder.
`timescale 1ns / 1ps
`default_nettype none

module smfd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               track_valid,
    input wire logic               track_stall,
    input wire smfd_pkg::smfd_in_t  track_item,
    input wire logic               evt_valid,
    input wire logic               evt_stall,
    input wire smfd_pkg::smfd_out_t evt_item
);
    import smfd_pkg::*;

    // Hold a stalled result.
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt_item))
        else $error("stalled result changed");

    // Channel and unsupported results always close their event.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.kind != KIND_META_HDR && evt_item.kind != KIND_META_DATA
        |-> evt_item.last)
        else $error("single-item result without last");

    // A meta header is last exactly when its payload is empty.
    a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.kind == KIND_META_HDR
        |-> evt_item.last == (evt_item.meta_length == 32'd0))
        else $error("meta header last flag disagrees with length");

    // Only pitch results use the upper bits of value1.
    a_value1_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.kind != KIND_PITCH |-> evt_item.value1[13:8] == 6'd0)
        else $error("value1 upper bits set outside pitch result");

endmodule

bind smf_event_decoder smfd_checker u_smfd_checker (.*);

`default_nettype wire
